FILE: hdl/cbb_pkg.sv
// Shared widths, constants and register codes for the cylindrical billboard basis block.
`timescale 1ns / 1ps
package cbb_pkg;

  // Fixed field widths
  localparam int YO_W     = 18;   // y_offset, signed Q18.0
  localparam int WID_W    = 16;   // quad_width, quad_height, material
  localparam int RIGHT_W  = 18;   // right_x, right_z
  localparam int FWD_W    = 16;   // forward_x, forward_z, signed Q1.14

  localparam int IN_FIXED_BITS  = YO_W + 3 * WID_W;
  localparam int OUT_FIXED_BITS = 2 * RIGHT_W + 2 * FWD_W + 2 * WID_W;

  // Normalizer datapath
  localparam int AX_W       = 24;            // |d| after range shift, always below 2^24
  localparam int SQ_W       = 2 * AX_W;      // one squared component
  localparam int LSQ_W      = SQ_W + 1;      // sum of squares
  localparam int FRAC_SHIFT = 14;            // radicand = lsq * 2^14
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CUR_W      = REM_W + 2;
  localparam int NUM_SHIFT  = 22;            // numerator = ax * 2^22 + q
  localparam int NUM_W      = AX_W + NUM_SHIFT + 1;
  localparam int DEN_W      = ROOT_W + 1;    // 2q
  localparam int QUO_W      = 16;
  localparam int CMP_W      = DEN_W + QUO_W;

  // Forward magnitude and right-axis scaling
  localparam int FQ_W     = 15;
  localparam logic [FQ_W-1:0] ONE_Q14 = 15'd16384;
  localparam int PROD_W   = FQ_W + WID_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = 31'd8192;
  localparam int RMAG_W   = PROD_W - FRAC_SHIFT;

  // Degenerate-direction test: |dx|^2 + |dz|^2 <= 16 raw units
  localparam int FB_AXIS_LIMIT = 5;
  localparam int FB_SUM_W      = 7;
  localparam logic [FB_SUM_W-1:0] FB_SUM_MAX = 7'd16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Z = 1'b1;

endpackage

FILE: hdl/cbb_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
`timescale 1ns / 1ps
module cbb_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cbb_pkg::RAD_W-1:0]  rad,
  output logic [cbb_pkg::ROOT_W-1:0] root
);

  localparam int STEPS = cbb_pkg::ROOT_W;

  logic [cbb_pkg::REM_W-1:0]  rem_q  [STEPS];
  logic [cbb_pkg::ROOT_W-1:0] root_q [STEPS];
  logic [cbb_pkg::RAD_W-1:0]  rad_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [cbb_pkg::REM_W-1:0]  rem_in;
    logic [cbb_pkg::ROOT_W-1:0] root_in;
    logic [cbb_pkg::RAD_W-1:0]  rad_in;
    logic [cbb_pkg::CUR_W-1:0]  cur;
    logic [cbb_pkg::CUR_W-1:0]  trial;
    logic                       ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
      cur   = {rem_in, rad_in[cbb_pkg::RAD_W-1 -: 2]};
      trial = cbb_pkg::CUR_W'({root_in, 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? cbb_pkg::REM_W'(cur - trial) : cbb_pkg::REM_W'(cur);
        root_q[k] <= {root_in[cbb_pkg::ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_in[cbb_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule

FILE: hdl/cbb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module cbb_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cbb_pkg::NUM_W-1:0] num,
  input  logic [cbb_pkg::DEN_W-1:0] den,
  output logic [cbb_pkg::QUO_W-1:0] quo
);

  localparam int STEPS = cbb_pkg::QUO_W;

  logic [cbb_pkg::NUM_W-1:0] rem_q [STEPS];
  logic [cbb_pkg::DEN_W-1:0] den_q [STEPS];
  logic [cbb_pkg::QUO_W-1:0] quo_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = STEPS - 1 - k;
    logic [cbb_pkg::NUM_W-1:0] rem_in;
    logic [cbb_pkg::DEN_W-1:0] den_in;
    logic [cbb_pkg::QUO_W-1:0] quo_in;
    logic [cbb_pkg::CMP_W-1:0] dsh;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // subtract the divisor aligned to this quotient bit when it fits
    always_comb begin
      dsh = cbb_pkg::CMP_W'(den_in) << SH;
      ge  = (cbb_pkg::CMP_W'(rem_in) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? cbb_pkg::NUM_W'(cbb_pkg::CMP_W'(rem_in) - dsh) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[cbb_pkg::QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[STEPS-1];

endmodule

FILE: hdl/cylindrical_billboard_basis.sv
// Top level: Y-locked billboard basis generator, one instance per transaction.
// Depth: the 32-stage square root and the 16-stage divider of the normalizer set most of
//   the pipeline depth between accepting an instance and m_tvalid.
// Throughput: one instance per cycle; s_tready drops only while the skid holds a result.
// Reset: rst (synchronous) clears all pipeline valids, output and skid, and sets both
//   targets to zero.
`timescale 1ns / 1ps
module cylindrical_billboard_basis #(
  parameter int COORD_WIDTH = 24,
  localparam int IN_W  = 8 * ((3 * COORD_WIDTH + cbb_pkg::IN_FIXED_BITS + 7) / 8),
  localparam int OUT_W = 8 * ((3 * COORD_WIDTH + cbb_pkg::OUT_FIXED_BITS + 7) / 8)
) (
  input  logic                          clk,
  input  logic                          rst,
  // instance stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // base_x, base_y, base_z, y_offset, quad_width, quad_height, material_id
  input  logic [IN_W-1:0]               s_tdata,
  // basis stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // right_x, right_z, up_y, forward_x, forward_z, center_x, center_y, center_z,
  // material_out
  output logic [OUT_W-1:0]              m_tdata,
  // configuration writes
  input  logic                          cfg_wen,
  input  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;                       // target minus base
  localparam int CYW   = ((CW > cbb_pkg::YO_W) ? CW : cbb_pkg::YO_W) + 1;
  localparam int SHIFT = (CW > cbb_pkg::AX_W) ? CW - cbb_pkg::AX_W : 0;
  localparam int WW    = cbb_pkg::WID_W;

  // instance fields that ride along untouched: {mat, hgt, wid, bz, cy, bx}
  localparam int R_BX   = 0;
  localparam int R_CY   = CW;
  localparam int R_BZ   = 2 * CW;
  localparam int R_WID  = 3 * CW;
  localparam int R_HGT  = 3 * CW + WW;
  localparam int R_MAT  = 3 * CW + 2 * WW;
  localparam int REST_W = 3 * CW + 3 * WW;

  // input field offsets in s_tdata
  localparam int I_BY  = CW;
  localparam int I_BZ  = 2 * CW;
  localparam int I_YO  = 3 * CW;
  localparam int I_WID = 3 * CW + cbb_pkg::YO_W;
  localparam int I_HGT = I_WID + WW;
  localparam int I_MAT = I_HGT + WW;

  localparam logic signed [CYW-1:0] CY_MAX = {{(CYW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [CYW-1:0] CY_MIN = {{(CYW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  localparam int SQ_STEPS  = cbb_pkg::ROOT_W;
  localparam int DIV_STEPS = cbb_pkg::QUO_W;

  // ---------------------------------------------------------------------------
  // Configuration: camera target in the XZ plane
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] target_x;
  logic signed [CW-1:0] target_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_z <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        cbb_pkg::CFG_TARGET_X: target_x <= cfg_data;
        cbb_pkg::CFG_TARGET_Z: target_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage advances together unless the skid is occupied.
  // The skid catches the one result that can leave the pipe in a stalled cycle,
  // so the stall seen upstream comes from a register, never from m_tready.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_v;

  assign en       = !skid_v;
  assign s_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: center y with saturation, target minus base
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]           in_bx, in_by, in_bz;
  logic signed [cbb_pkg::YO_W-1:0] in_yo;
  logic signed [CYW-1:0]          cy_sum;
  logic        [CW-1:0]           cy_sat;

  assign in_bx = $signed(s_tdata[CW-1:0]);
  assign in_by = $signed(s_tdata[I_BY +: CW]);
  assign in_bz = $signed(s_tdata[I_BZ +: CW]);
  assign in_yo = $signed(s_tdata[I_YO +: cbb_pkg::YO_W]);

  always_comb begin
    cy_sum = CYW'(in_by) + CYW'(in_yo);
    priority if (cy_sum > CY_MAX) begin
      cy_sat = CY_MAX[CW-1:0];
    end else if (cy_sum < CY_MIN) begin
      cy_sat = CY_MIN[CW-1:0];
    end else begin
      cy_sat = cy_sum[CW-1:0];
    end
  end

  logic                 v1;
  logic signed [DW-1:0] s1_dx, s1_dz;
  logic [REST_W-1:0]    s1_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= DW'(target_x) - DW'(in_bx);
      s1_dz   <= DW'(target_z) - DW'(in_bz);
      s1_rest <= {s_tdata[I_MAT +: WW], s_tdata[I_HGT +: WW], s_tdata[I_WID +: WW],
                  s_tdata[I_BZ +: CW], cy_sat, s_tdata[CW-1:0]};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: split each difference into sign and magnitude
  // ---------------------------------------------------------------------------
  logic              v2;
  logic              s2_sx, s2_sz;
  logic [CW-1:0]     s2_adx, s2_adz;
  logic [REST_W-1:0] s2_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sx   <= s1_dx[DW-1];
      s2_sz   <= s1_dz[DW-1];
      s2_adx  <= CW'(s1_dx[DW-1] ? -s1_dx : s1_dx);
      s2_adz  <= CW'(s1_dz[DW-1] ? -s1_dz : s1_dz);
      s2_rest <= s1_rest;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: range shift, squares, degenerate-direction test
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::AX_W-1:0]     ax_c, az_c;
  logic [cbb_pkg::FB_SUM_W-1:0] fb_sum;
  logic                         fb_c;

  always_comb begin
    ax_c   = cbb_pkg::AX_W'(s2_adx >> SHIFT);
    az_c   = cbb_pkg::AX_W'(s2_adz >> SHIFT);
    // both magnitudes below five, so their low three bits are the whole value
    fb_sum = cbb_pkg::FB_SUM_W'(s2_adx[2:0]) * cbb_pkg::FB_SUM_W'(s2_adx[2:0])
           + cbb_pkg::FB_SUM_W'(s2_adz[2:0]) * cbb_pkg::FB_SUM_W'(s2_adz[2:0]);
    fb_c   = (s2_adx < CW'(cbb_pkg::FB_AXIS_LIMIT)) &&
             (s2_adz < CW'(cbb_pkg::FB_AXIS_LIMIT)) &&
             (fb_sum <= cbb_pkg::FB_SUM_MAX);
  end

  logic                      v3;
  logic                      s3_sx, s3_sz, s3_fb;
  logic [cbb_pkg::AX_W-1:0]  s3_ax, s3_az;
  logic [cbb_pkg::SQ_W-1:0]  s3_sqx, s3_sqz;
  logic [REST_W-1:0]         s3_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sx   <= s2_sx;
      s3_sz   <= s2_sz;
      s3_fb   <= fb_c;
      s3_ax   <= ax_c;
      s3_az   <= az_c;
      s3_sqx  <= cbb_pkg::SQ_W'(ax_c) * cbb_pkg::SQ_W'(ax_c);
      s3_sqz  <= cbb_pkg::SQ_W'(az_c) * cbb_pkg::SQ_W'(az_c);
      s3_rest <= s2_rest;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squared length, scaled for a Q.7 root
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::LSQ_W-1:0] lsq_c;

  assign lsq_c = cbb_pkg::LSQ_W'(s3_sqx) + cbb_pkg::LSQ_W'(s3_sqz);

  logic                      v4;
  logic                      s4_sx, s4_sz, s4_fb;
  logic [cbb_pkg::AX_W-1:0]  s4_ax, s4_az;
  logic [cbb_pkg::RAD_W-1:0] s4_rad;
  logic [REST_W-1:0]         s4_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sx   <= s3_sx;
      s4_sz   <= s3_sz;
      s4_fb   <= s3_fb;
      s4_ax   <= s3_ax;
      s4_az   <= s3_az;
      s4_rad  <= cbb_pkg::RAD_W'(lsq_c) << cbb_pkg::FRAC_SHIFT;
      s4_rest <= s3_rest;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root, with the item's other fields delayed alongside
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::ROOT_W-1:0] root;

  cbb_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s4_rad),
    .root (root)
  );

  logic                     a_v    [SQ_STEPS];
  logic                     a_sx   [SQ_STEPS];
  logic                     a_sz   [SQ_STEPS];
  logic                     a_fb   [SQ_STEPS];
  logic [cbb_pkg::AX_W-1:0] a_ax   [SQ_STEPS];
  logic [cbb_pkg::AX_W-1:0] a_az   [SQ_STEPS];
  logic [REST_W-1:0]        a_rest [SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      a_sx[0]   <= s4_sx;
      a_sz[0]   <= s4_sz;
      a_fb[0]   <= s4_fb;
      a_ax[0]   <= s4_ax;
      a_az[0]   <= s4_az;
      a_rest[0] <= s4_rest;
      for (int i = 1; i < SQ_STEPS; i++) begin
        a_sx[i]   <= a_sx[i-1];
        a_sz[i]   <= a_sz[i-1];
        a_fb[i]   <= a_fb[i-1];
        a_ax[i]   <= a_ax[i-1];
        a_az[i]   <= a_az[i-1];
        a_rest[i] <= a_rest[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: divider operands, num = ax * 2^22 + q and den = 2q (q forced to 1
  // when the length is zero)
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::ROOT_W-1:0] q_c;

  assign q_c = (root == '0) ? cbb_pkg::ROOT_W'(1) : root;

  logic                      v5;
  logic                      s5_sx, s5_sz, s5_fb;
  logic [cbb_pkg::NUM_W-1:0] s5_num_x, s5_num_z;
  logic [cbb_pkg::DEN_W-1:0] s5_den;
  logic [REST_W-1:0]         s5_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sx    <= a_sx[SQ_STEPS-1];
      s5_sz    <= a_sz[SQ_STEPS-1];
      s5_fb    <= a_fb[SQ_STEPS-1];
      s5_num_x <= (cbb_pkg::NUM_W'(a_ax[SQ_STEPS-1]) << cbb_pkg::NUM_SHIFT)
                + cbb_pkg::NUM_W'(q_c);
      s5_num_z <= (cbb_pkg::NUM_W'(a_az[SQ_STEPS-1]) << cbb_pkg::NUM_SHIFT)
                + cbb_pkg::NUM_W'(q_c);
      s5_den   <= {q_c, 1'b0};
      s5_rest  <= a_rest[SQ_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Two dividers share the denominator; the quotient rounds half away from zero
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::QUO_W-1:0] quo_x, quo_z;

  cbb_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (s5_num_x),
    .den (s5_den),
    .quo (quo_x)
  );

  cbb_div u_div_z (
    .clk (clk),
    .en  (en),
    .num (s5_num_z),
    .den (s5_den),
    .quo (quo_z)
  );

  logic              b_v    [DIV_STEPS];
  logic              b_sx   [DIV_STEPS];
  logic              b_sz   [DIV_STEPS];
  logic              b_fb   [DIV_STEPS];
  logic [REST_W-1:0] b_rest [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      b_sx[0]   <= s5_sx;
      b_sz[0]   <= s5_sz;
      b_fb[0]   <= s5_fb;
      b_rest[0] <= s5_rest;
      for (int i = 1; i < DIV_STEPS; i++) begin
        b_sx[i]   <= b_sx[i-1];
        b_sz[i]   <= b_sz[i-1];
        b_fb[i]   <= b_fb[i-1];
        b_rest[i] <= b_rest[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: cap at one, apply the fallback and the signs
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::FQ_W-1:0] cap_x, cap_z, mag_x, mag_z;
  logic                     neg_x, neg_z;

  always_comb begin
    cap_x = (quo_x > cbb_pkg::QUO_W'(cbb_pkg::ONE_Q14)) ? cbb_pkg::ONE_Q14
                                                        : cbb_pkg::FQ_W'(quo_x);
    cap_z = (quo_z > cbb_pkg::QUO_W'(cbb_pkg::ONE_Q14)) ? cbb_pkg::ONE_Q14
                                                        : cbb_pkg::FQ_W'(quo_z);
    // target over the center: face +Z
    mag_x = b_fb[DIV_STEPS-1] ? '0 : cap_x;
    mag_z = b_fb[DIV_STEPS-1] ? cbb_pkg::ONE_Q14 : cap_z;
    neg_x = b_sx[DIV_STEPS-1] && !b_fb[DIV_STEPS-1];
    neg_z = b_sz[DIV_STEPS-1] && !b_fb[DIV_STEPS-1];
  end

  logic                               v6;
  logic                               s6_neg_x, s6_neg_z;
  logic [cbb_pkg::FQ_W-1:0]           s6_mag_x, s6_mag_z;
  logic signed [cbb_pkg::FWD_W-1:0]   s6_fx, s6_fz;
  logic [REST_W-1:0]                  s6_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_neg_x <= neg_x;
      s6_neg_z <= neg_z;
      s6_mag_x <= mag_x;
      s6_mag_z <= mag_z;
      s6_fx    <= neg_x ? -cbb_pkg::FWD_W'(mag_x) : cbb_pkg::FWD_W'(mag_x);
      s6_fz    <= neg_z ? -cbb_pkg::FWD_W'(mag_z) : cbb_pkg::FWD_W'(mag_z);
      s6_rest  <= b_rest[DIV_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: right = (fz, -fx) times width, rounding term added
  // ---------------------------------------------------------------------------
  logic [WW-1:0] wid6;

  assign wid6 = s6_rest[R_WID +: WW];

  logic                             v7;
  logic                             s7_rx_neg, s7_rz_neg;
  logic [cbb_pkg::PROD_W-1:0]       s7_prx, s7_prz;
  logic signed [cbb_pkg::FWD_W-1:0] s7_fx, s7_fz;
  logic [REST_W-1:0]                s7_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_rx_neg <= s6_neg_z;
      s7_rz_neg <= !s6_neg_x;   // -fx; a zero magnitude stays zero either way
      s7_prx    <= cbb_pkg::PROD_W'(s6_mag_z) * cbb_pkg::PROD_W'(wid6)
                 + cbb_pkg::ROUND_HALF;
      s7_prz    <= cbb_pkg::PROD_W'(s6_mag_x) * cbb_pkg::PROD_W'(wid6)
                 + cbb_pkg::ROUND_HALF;
      s7_fx     <= s6_fx;
      s7_fz     <= s6_fz;
      s7_rest   <= s6_rest;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: drop the Q14 fraction, sign the right axis, pack the result
  // ---------------------------------------------------------------------------
  logic [cbb_pkg::RMAG_W-1:0]        rmag_x, rmag_z;
  logic [cbb_pkg::RIGHT_W-1:0]       right_x, right_z;
  logic [OUT_W-1:0]                  pack_c;

  always_comb begin
    rmag_x  = s7_prx[cbb_pkg::PROD_W-1:cbb_pkg::FRAC_SHIFT];
    rmag_z  = s7_prz[cbb_pkg::PROD_W-1:cbb_pkg::FRAC_SHIFT];
    right_x = s7_rx_neg ? -cbb_pkg::RIGHT_W'(rmag_x) : cbb_pkg::RIGHT_W'(rmag_x);
    right_z = s7_rz_neg ? -cbb_pkg::RIGHT_W'(rmag_z) : cbb_pkg::RIGHT_W'(rmag_z);
    pack_c  = OUT_W'({s7_rest[R_MAT +: WW], s7_rest[R_BZ +: CW], s7_rest[R_CY +: CW],
                      s7_rest[R_BX +: CW], s7_fz, s7_fx, s7_rest[R_HGT +: WW],
                      right_z, right_x});
  end

  logic             v8;
  logic [OUT_W-1:0] s8_data;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_data <= pack_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits travel with their items
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      for (int i = 0; i < SQ_STEPS; i++) begin
        a_v[i] <= 1'b0;
      end
      for (int i = 0; i < DIV_STEPS; i++) begin
        b_v[i] <= 1'b0;
      end
    end else if (en) begin
      v1     <= s_tvalid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      a_v[0] <= v4;
      for (int i = 1; i < SQ_STEPS; i++) begin
        a_v[i] <= a_v[i-1];
      end
      v5     <= a_v[SQ_STEPS-1];
      b_v[0] <= v5;
      for (int i = 1; i < DIV_STEPS; i++) begin
        b_v[i] <= b_v[i-1];
      end
      v6 <= b_v[DIV_STEPS-1];
      v7 <= v6;
      v8 <= v7;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid
  // ---------------------------------------------------------------------------
  logic             out_v;
  logic [OUT_W-1:0] out_data;
  logic [OUT_W-1:0] skid_data;
  logic             take;

  assign take     = out_v && m_tready;
  assign m_tvalid = out_v;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      // pipe is frozen; drain the skid into the output once it frees up
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (!out_v || take) begin
      out_v <= v8;
    end else if (v8) begin
      // output still held: park the leaving result
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (!out_v || take) begin
      out_data <= s8_data;
    end else begin
      skid_data <= s8_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid holds a result while the output register is empty");

  a_skid_catches : assert property (@(posedge clk) disable iff (rst)
    (en && v8 && out_v && !m_tready) |=> skid_v)
    else $error("result left the pipe while the output was stalled and was not parked");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (skid_v && m_tready) |=> (!skid_v && out_v))
    else $error("skid did not drain after the output transaction");

endmodule

FILE: verif/tb_cylindrical_billboard_basis.sv
// Self-checking testbench for the cylindrical billboard basis block.
`timescale 1ns / 1ps
module tb_cylindrical_billboard_basis;

  localparam int COORD_W = 24;
  localparam int IN_W    = 8 * ((3 * COORD_W + cbb_pkg::IN_FIXED_BITS + 7) / 8);
  localparam int OUT_W   = 8 * ((3 * COORD_W + cbb_pkg::OUT_FIXED_BITS + 7) / 8);
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint NEAR_LSQ  = 16;     // squared XZ distance treated as "on top of target"
  localparam longint UNIT_Q14  = 16384;  // 1.0 in Q1.14
  localparam int RANDOM_PER_PHASE = 108;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // base_x, base_y, base_z, y_offset, quad_width, quad_height, material_id, zero pad
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // right_x, right_z, up_y, forward_x, forward_z, center_x, center_y, center_z,
  // material_out, zero pad
  logic [OUT_W-1:0]       m_tdata;
  logic                   cfg_wen = 1'b0;
  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index = cbb_pkg::CFG_TARGET_X;
  logic [COORD_W-1:0]     cfg_data = '0;

  typedef struct {
    logic signed [cbb_pkg::RIGHT_W-1:0] right_x;
    logic signed [cbb_pkg::RIGHT_W-1:0] right_z;
    logic [cbb_pkg::WID_W-1:0]          up_y;
    logic signed [cbb_pkg::FWD_W-1:0]   forward_x;
    logic signed [cbb_pkg::FWD_W-1:0]   forward_z;
    logic signed [COORD_W-1:0]          center_x;
    logic signed [COORD_W-1:0]          center_y;
    logic signed [COORD_W-1:0]          center_z;
    logic [cbb_pkg::WID_W-1:0]          material_out;
  } basis_t;

  typedef struct {
    logic [IN_W-1:0] data;
    bit              drain_first;  // hold this instance until every basis has come back
  } instance_t;

  // Testbench copy of the camera target registers
  logic signed [COORD_W-1:0] target_x = '0;
  logic signed [COORD_W-1:0] target_z = '0;

  instance_t   instance_q[$];   // instances waiting to be offered
  basis_t      basis_exp_q[$];  // predicted bases, oldest first
  int unsigned offered_cnt  = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  cylindrical_billboard_basis #(.COORD_WIDTH(COORD_W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Exact integer square root, one result bit per pair of radicand bits.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem, root, probe;
    rem   = n;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // round(a * w / 2^14) with ties away from zero
  function automatic longint scale_by_width(input longint a,
                                            input logic [cbb_pkg::WID_W-1:0] w);
    longint unsigned mag;
    mag = (a < 0) ? -a : a;
    mag = (mag * longint'(w) + 64'd8192) >> 14;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Work out the basis the block must return for one instance, using the
  // target registers as they stand now.
  function automatic basis_t predict_basis(input logic [IN_W-1:0] d);
    logic signed [COORD_W-1:0]      bx, by, bz;
    logic signed [cbb_pkg::YO_W-1:0] yo;
    logic [cbb_pkg::WID_W-1:0]      wid;
    longint                         cy, dx, dz, fx, fz;
    longint unsigned                adx, adz, root, mx, mz;
    basis_t                         r;
    bx  = d[23:0];
    by  = d[47:24];
    bz  = d[71:48];
    yo  = d[89:72];
    wid = d[105:90];

    cy = longint'(by) + longint'(yo);
    if (cy > COORD_MAX) cy = COORD_MAX;
    else if (cy < COORD_MIN) cy = COORD_MIN;

    dx  = longint'(target_x) - longint'(bx);
    dz  = longint'(target_z) - longint'(bz);
    adx = (dx < 0) ? -dx : dx;
    adz = (dz < 0) ? -dz : dz;

    if (adx < 4096 && adz < 4096 && adx * adx + adz * adz <= NEAR_LSQ) begin
      // camera straight above the center: face +Z
      fx = 0;
      fz = UNIT_Q14;
    end else begin
      // 24-bit coordinates need no range shift before squaring
      root = floor_sqrt((adx * adx + adz * adz) << 14);
      mx   = ((adx << 22) + root) / (2 * root);
      mz   = ((adz << 22) + root) / (2 * root);
      if (mx > UNIT_Q14) mx = UNIT_Q14;
      if (mz > UNIT_Q14) mz = UNIT_Q14;
      fx = (dx < 0) ? -longint'(mx) : longint'(mx);
      fz = (dz < 0) ? -longint'(mz) : longint'(mz);
    end

    r.right_x      = cbb_pkg::RIGHT_W'(scale_by_width(fz, wid));
    r.right_z      = cbb_pkg::RIGHT_W'(scale_by_width(-fx, wid));
    r.up_y         = d[121:106];
    r.forward_x    = cbb_pkg::FWD_W'(fx);
    r.forward_z    = cbb_pkg::FWD_W'(fz);
    r.center_x     = bx;
    r.center_y     = COORD_W'(cy);
    r.center_z     = bz;
    r.material_out = d[137:122];
    return r;
  endfunction

  function automatic basis_t unpack_basis(input logic [OUT_W-1:0] t);
    basis_t r;
    r.right_x      = t[17:0];
    r.right_z      = t[35:18];
    r.up_y         = t[51:36];
    r.forward_x    = t[67:52];
    r.forward_z    = t[83:68];
    r.center_x     = t[107:84];
    r.center_y     = t[131:108];
    r.center_z     = t[155:132];
    r.material_out = t[171:156];
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Queue one instance; fields wider than needed are cut to the port widths.
  task automatic add_instance(input longint bx, by, bz, yo,
                              input int unsigned w, h, mat, input bit drain_first = 1'b0);
    instance_t it;
    it.data          = '0;
    it.data[23:0]    = bx[23:0];
    it.data[47:24]   = by[23:0];
    it.data[71:48]   = bz[23:0];
    it.data[89:72]   = yo[17:0];
    it.data[105:90]  = w[15:0];
    it.data[121:106] = h[15:0];
    it.data[137:122] = mat[15:0];
    it.drain_first   = drain_first;
    instance_q = {instance_q, it};
  endtask

  // Base coordinate at a random distance scale from the target, so the
  // normalizer sees every magnitude from a few LSBs up to the full span.
  function automatic longint base_near(input longint tgt);
    longint d;
    d = longint'($urandom) & ((longint'(1) << $urandom_range(24)) - 1);
    if ($urandom_range(1) == 1) d = -d;
    if (tgt - d > COORD_MAX || tgt - d < COORD_MIN) return tgt + d;
    return tgt - d;
  endfunction

  task automatic add_random_instance(input bit drain_first);
    int     kind, off_x, off_z;
    longint bx, by, bz;
    int unsigned w;
    kind = $urandom_range(99);
    if (kind < 50) begin
      bx = base_near(target_x);
      bz = base_near(target_z);
    end else if (kind < 65) begin
      // hover around the fallback radius
      off_x = int'($urandom_range(10)) - 5;
      off_z = int'($urandom_range(10)) - 5;
      bx = longint'(target_x) + off_x;
      bz = longint'(target_z) + off_z;
    end else begin
      bx = longint'($urandom);
      bz = longint'($urandom);
    end
    case ($urandom_range(9))
      0:       by = COORD_MAX - longint'($urandom_range(150000));
      1:       by = COORD_MIN + longint'($urandom_range(150000));
      default: by = longint'($urandom);
    endcase
    case ($urandom_range(9))
      0:       w = 0;
      1:       w = 16'hFFFF;
      default: w = $urandom;
    endcase
    add_instance(bx, by, bz, longint'($urandom), w, $urandom, $urandom, drain_first);
  endtask

  // Write one target register; only called while nothing is in flight.
  task automatic write_target(input logic [cbb_pkg::CFG_IDX_W-1:0] idx,
                              input logic signed [COORD_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      cbb_pkg::CFG_TARGET_X: target_x = v;
      cbb_pkg::CFG_TARGET_Z: target_z = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Return once every queued instance has been taken and every basis checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (instance_q.size() != 0 || offered_cnt != accepted_cnt || basis_exp_q.size() != 0);
  endtask

  // Driver: advance to the next instance once the current transaction is taken,
  // otherwise hold data and valid steady. Idle gaps are rolled per cycle.
  always @(negedge clk) begin : drive_instances
    bit        slot_free;
    instance_t it;
    slot_free = !s_tvalid || (offered_cnt == accepted_cnt);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (slot_free) begin
      if (instance_q.size() != 0 &&
          !(instance_q[0].drain_first && basis_exp_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        it = instance_q.pop_front();
        offered_cnt++;
        s_tdata  <= it.data;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on every accepted instance, check every accepted basis
  // against the oldest prediction.
  always @(posedge clk) begin : monitor
    basis_t got, want;
    if (!rst && s_tvalid && s_tready) begin
      basis_exp_q = {basis_exp_q, predict_basis(s_tdata)};
      accepted_cnt++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_basis(m_tdata);
      if (basis_exp_q.size() == 0) begin
        $error("basis transaction with no instance outstanding");
        fail_cnt++;
      end else begin
        want = basis_exp_q.pop_front();
        check_field("right_x",      want.right_x,      got.right_x);
        check_field("right_z",      want.right_z,      got.right_z);
        check_field("up_y",         want.up_y,         got.up_y);
        check_field("forward_x",    want.forward_x,    got.forward_x);
        check_field("forward_z",    want.forward_z,    got.forward_z);
        check_field("center_x",     want.center_x,     got.center_x);
        check_field("center_y",     want.center_y,     got.center_y);
        check_field("center_z",     want.center_z,     got.center_z);
        check_field("material_out", want.material_out, got.material_out);
      end
    end
  end

  // Stimulus: six phases, each with a new target and one of four idling patterns.
  // Phase 0 carries the directed cases around the origin, phase 1 those at
  // the far corners of the coordinate range.
  initial begin : stimulus
    int p, i;
    logic signed [COORD_W-1:0] tx, tz;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: begin tx = '0; tz = '0; end
        1: begin tx = COORD_W'(COORD_MAX); tz = COORD_W'(COORD_MIN); end
        2: begin tx = COORD_W'(COORD_MIN); tz = COORD_W'(COORD_MAX); end
        5: begin
          tx = COORD_W'(int'($urandom_range(200)) - 100);
          tz = COORD_W'(int'($urandom_range(200)) - 100);
        end
        default: begin tx = COORD_W'($urandom); tz = COORD_W'($urandom); end
      endcase
      write_target(cbb_pkg::CFG_TARGET_X, tx);
      write_target(cbb_pkg::CFG_TARGET_Z, tz);

      // no idling, sender idle, receiver stalling, both
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase

      if (p == 0) begin
        // target right on the center, then around the fallback radius
        add_instance(0, 0, 0, 0, 16'h1000, 16'h1000, 0);
        add_instance(-4, 0, 0, 0, 16'hFFFF, 16'h0800, 1);   // exactly on the radius
        add_instance(0, 0, 4, 0, 16'h2000, 0, 2);
        add_instance(-2, 0, 2, 0, 16'h1000, 1, 3);
        add_instance(-3, 0, -3, 0, 16'h1000, 2, 4);         // just outside
        add_instance(5, 0, 0, 0, 16'h1000, 3, 5);
        // axis-aligned and diagonal facing
        add_instance(-4096, 0, 0, 0, 16'h1000, 4, 6);
        add_instance(4096, 0, 0, 0, 16'h1000, 5, 7);
        add_instance(0, 0, -4096, 0, 16'h1000, 6, 8);
        add_instance(0, 0, 4096, 0, 16'h1000, 7, 9);
        add_instance(4096, 0, 4096, 0, 16'hFFFF, 8, 10);
        // center y saturation and its boundaries
        add_instance(-12345, COORD_MAX, 6789, 131071, 16'h3000, 9, 11);
        add_instance(777, COORD_MIN, -999, -131072, 16'h3000, 10, 12);
        add_instance(1, COORD_MAX - 5, 1, 5, 16'h0001, 11, 13);
        add_instance(1, COORD_MIN + 65536, 1, -65536, 16'h0001, 12, 14);
        // field extremes
        add_instance(COORD_MAX, COORD_MAX, COORD_MAX, 65536, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_instance(COORD_MIN, COORD_MIN, COORD_MIN, -65536, 0, 0, 0);
        add_instance(3, -1, -1, -1, 16'hFFFF, 16'hAAAA, 16'h5555);
      end else if (p == 1) begin
        // largest distances the registers allow, and the target on a corner
        add_instance(COORD_MIN, 0, COORD_MAX, 0, 16'hFFFF, 16'h1234, 20);
        add_instance(COORD_MIN, 0, COORD_MIN, 0, 16'hFFFF, 16'h4321, 21);
        add_instance(COORD_MAX, 0, COORD_MIN, 0, 16'h8000, 16'h1111, 22);
        add_instance(COORD_MAX - 3, 0, COORD_MIN + 2, 0, 16'h8000, 16'h2222, 23);
      end

      // Some instances make the sender wait for every basis before going on.
      for (i = 0; i < RANDOM_PER_PHASE; i++)
        add_random_instance(i == 40 || $urandom_range(79) == 0);
    end

    wait_drained();
    // let any stray basis show up past the pipeline depth
    repeat (80) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS cylindrical_billboard_basis");
    end else begin
      $display("FAIL cylindrical_billboard_basis");
    end
    $finish;
  end

  // Watchdog: a correct run ends well under a tenth of this.
  initial begin
    #5_000_000;
    $display("FAIL cylindrical_billboard_basis");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cbb_pkg.sv
hdl/cbb_isqrt.sv
hdl/cbb_div.sv
hdl/cylindrical_billboard_basis.sv
verif/tb_cylindrical_billboard_basis.sv
